[sv/exclusive_cache_hierarchy_victim_assert.svh]
// Assertion macros used by the checker file of the cache hierarchy.
`ifndef EXCLUSIVE_CACHE_HIERARCHY_VICTIM_ASSERT_SVH
`define EXCLUSIVE_CACHE_HIERARCHY_VICTIM_ASSERT_SVH

// Checks that cons holds on the same edge whenever ante holds.
`define ECHV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds on the next edge after ante holds.
`define ECHV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ech_pkg.sv]
// Shared types and constants of the exclusive cache hierarchy.
package ech_pkg;

    localparam int ADDR_W = 12;
    localparam int WORD_W = 32;
    localparam int BLK_W  = ADDR_W - 2;
    localparam int CNT_W  = 32;
    localparam int LVL_W  = 2;

    // Level codes reported with each result.
    localparam logic [LVL_W-1:0] LVL_L1  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_VB  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_L2  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_MEM = 2'd3;

    // One decoded request as it waits in the queue.
    typedef struct packed {
        logic              is_read;
        logic [BLK_W-1:0]  blk;
        logic [WORD_W-1:0] wdata;
    } ech_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_L2RD,
        ST_L2WR,
        ST_DONE
    } ech_state_t;

endpackage

[sv/ech_front.sv]
// Front end: accepts requests, decodes the block number and queues them.
module ech_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          is_read,
    input  logic [ech_pkg::ADDR_W-1:0]    address,
    input  logic [ech_pkg::WORD_W-1:0]    write_data,
    input  logic                          hold,
    output logic                          head_valid,
    output ech_pkg::ech_req_t             head,
    input  logic                          pop
);
    import ech_pkg::*;

    ech_req_t    q_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    ech_req_t    req;

    // Classify the incoming request; the two low address bits are dropped.
    always_comb
    begin
        req.is_read = is_read;
        req.blk     = address[ADDR_W-1:2];
        req.wdata   = write_data;
    end

    assign in_stall   = (cnt_reg == 2'd2) || hold;
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

[sv/ech_back.sv]
// Back end: L1, victim buffer, L2 and main memory, one request at a time.
module ech_back #(
    parameter int L1_SETS        = 16,
    parameter int VICTIM_ENTRIES = 4,
    parameter int L2_SETS        = 16,
    parameter int L2_WAYS        = 8,
    parameter int MEM_BYTES      = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ech_pkg::ech_req_t             head,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ech_pkg::WORD_W-1:0]    read_data,
    output logic [ech_pkg::LVL_W-1:0]     hit_level,
    output logic [ech_pkg::CNT_W-1:0]     l1_miss_count,
    output logic [ech_pkg::CNT_W-1:0]     victim_miss_count,
    output logic [ech_pkg::CNT_W-1:0]     l2_miss_count
);
    import ech_pkg::*;

    localparam int L1_IW     = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
    localparam int L2_IW     = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
    localparam int VI_W      = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
    localparam int VN_W      = $clog2(VICTIM_ENTRIES + 1);
    localparam int WL_W      = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int WN_W      = $clog2(L2_WAYS + 1);
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int MW_W      = $clog2(MEM_WORDS);

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [WORD_W-1:0] data;
    } l1_line_t;

    typedef struct packed {
        logic              valid;
        logic [BLK_W-1:0]  blk;
        logic [WL_W-1:0]   lru;
        logic [WORD_W-1:0] data;
    } l2_way_t;

    typedef l2_way_t [L2_WAYS-1:0] l2_row_t;

    // State machine.
    ech_state_t state_reg, state_next;

    // Current request and cascade candidate.
    ech_req_t          cur_reg, cur_next;
    logic [BLK_W-1:0]  ev_blk_reg, ev_blk_next;
    logic [WORD_W-1:0] ev_data_reg, ev_data_next;
    logic [MW_W-1:0]   clr_reg, clr_next;

    // L1: line memory plus valid flops.
    l1_line_t          l1_mem [L1_SETS];
    l1_line_t          l1_rd_reg;
    logic [L1_SETS-1:0] l1_valid_reg, l1_valid_next;
    logic              l1_we;
    logic [L1_IW-1:0]  l1_wa, l1_ra;
    l1_line_t          l1_wd;

    // Victim buffer registers.
    logic              v_valid_reg [VICTIM_ENTRIES];
    logic [BLK_W-1:0]  v_blk_reg   [VICTIM_ENTRIES];
    logic [VI_W-1:0]   v_lru_reg   [VICTIM_ENTRIES];
    logic [WORD_W-1:0] v_data_reg  [VICTIM_ENTRIES];
    logic              v_valid_next [VICTIM_ENTRIES];
    logic [BLK_W-1:0]  v_blk_next   [VICTIM_ENTRIES];
    logic [VI_W-1:0]   v_lru_next   [VICTIM_ENTRIES];
    logic [WORD_W-1:0] v_data_next  [VICTIM_ENTRIES];

    // L2: one row per set plus a row-written flop per set.
    l2_row_t           l2_mem [L2_SETS];
    l2_row_t           l2_rd_reg;
    logic [L2_IW-1:0]  l2_rset_reg;
    logic [L2_SETS-1:0] l2_ok_reg, l2_ok_next;
    logic              l2_we;
    logic [L2_IW-1:0]  l2_wa, l2_ra;
    l2_row_t           l2_wd, l2_row;

    // Main memory, one word per block.
    logic [WORD_W-1:0] mm_mem [MEM_WORDS];
    logic [WORD_W-1:0] mm_rd_reg;
    logic              mm_we;
    logic [MW_W-1:0]   mm_wa, mm_ra;
    logic [WORD_W-1:0] mm_wd;

    // Miss counters and result registers.
    logic [CNT_W-1:0]  l1m_reg, l1m_next, vm_reg, vm_next, l2m_reg, l2m_next;
    logic [WORD_W-1:0] res_data_reg, res_data_next;
    logic [LVL_W-1:0]  res_lvl_reg, res_lvl_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic [LVL_W-1:0]  out_lvl_reg, out_lvl_next;
    logic [CNT_W-1:0]  out_l1m_reg, out_l1m_next, out_vm_reg, out_vm_next;
    logic [CNT_W-1:0]  out_l2m_reg, out_l2m_next;

    logic              cascade;
    logic              out_free;

    assign out_free          = !out_valid_reg || !out_stall;
    assign clearing          = (state_reg == ST_CLEAR);
    assign pop               = (state_reg == ST_IDLE) && head_valid;
    assign out_valid         = out_valid_reg;
    assign read_data         = out_data_reg;
    assign hit_level         = out_lvl_reg;
    assign l1_miss_count     = out_l1m_reg;
    assign victim_miss_count = out_vm_reg;
    assign l2_miss_count     = out_l2m_reg;

    // Read addresses: the queue head while idle, the cascade set later.
    assign l1_ra = L1_IW'(head.blk % L1_SETS);
    assign mm_ra = MW_W'(head.blk % MEM_WORDS);
    assign l2_ra = (state_reg == ST_L2RD) ? L2_IW'(ev_blk_reg % L2_SETS)
                                          : L2_IW'(head.blk % L2_SETS);
    assign l2_row = l2_ok_reg[l2_rset_reg] ? l2_rd_reg : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == MW_W'(MEM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (head_valid) state_next = ST_LOOK;
            ST_LOOK:  state_next = cascade ? ST_L2RD : ST_DONE;
            ST_L2RD:  state_next = ST_L2WR;
            ST_L2WR:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Lookup, update and result datapath.
    always_comb
    begin : datapath
        logic [L1_IW-1:0]  idx;
        logic              l1_hit, v_hit, l2_hit, free_found;
        int                vh, wh, fi, oi;
        logic [VN_W-1:0]   vn;
        logic [WN_W-1:0]   wn;
        logic [VI_W-1:0]   vpos;
        logic [WL_W-1:0]   wpos;
        logic [WORD_W-1:0] rdata;
        l2_row_t           row;

        cur_next       = cur_reg;
        ev_blk_next    = ev_blk_reg;
        ev_data_next   = ev_data_reg;
        clr_next       = clr_reg;
        l1_valid_next  = l1_valid_reg;
        v_valid_next   = v_valid_reg;
        v_blk_next     = v_blk_reg;
        v_lru_next     = v_lru_reg;
        v_data_next    = v_data_reg;
        l2_ok_next     = l2_ok_reg;
        l1m_next       = l1m_reg;
        vm_next        = vm_reg;
        l2m_next       = l2m_reg;
        res_data_next  = res_data_reg;
        res_lvl_next   = res_lvl_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_lvl_next   = out_lvl_reg;
        out_l1m_next   = out_l1m_reg;
        out_vm_next    = out_vm_reg;
        out_l2m_next   = out_l2m_reg;
        l1_we = 1'b0;
        l1_wa = L1_IW'(cur_reg.blk % L1_SETS);
        l1_wd = '0;
        l2_we = 1'b0;
        l2_wa = l2_rset_reg;
        l2_wd = l2_row;
        mm_we = 1'b0;
        mm_wa = MW_W'(cur_reg.blk % MEM_WORDS);
        mm_wd = cur_reg.wdata;
        cascade = 1'b0;
        idx = L1_IW'(cur_reg.blk % L1_SETS);
        l1_hit = 1'b0;
        v_hit = 1'b0;
        l2_hit = 1'b0;
        free_found = 1'b0;
        vh = 0;
        wh = 0;
        fi = 0;
        oi = 0;
        vn = '0;
        wn = '0;
        vpos = '0;
        wpos = '0;
        rdata = mm_rd_reg;
        row = l2_row;

        case (state_reg)
            ST_CLEAR:
            begin
                mm_we    = 1'b1;
                mm_wa    = clr_reg;
                mm_wd    = '0;
                clr_next = clr_reg + MW_W'(1);
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    cur_next = head;
                end
            end
            ST_LOOK:
            begin
                mm_we  = !cur_reg.is_read;
                l1_hit = l1_valid_reg[idx] && (l1_rd_reg.blk == cur_reg.blk);
                // Search the victim buffer.
                for (int i = 0; i < VICTIM_ENTRIES; i++)
                begin
                    if (v_valid_reg[i])
                    begin
                        vn = vn + VN_W'(1);
                        if (!v_hit && v_blk_reg[i] == cur_reg.blk)
                        begin
                            v_hit = 1'b1;
                            vh    = i;
                        end
                    end
                end
                v_hit = v_hit && !l1_hit;
                // Search the L2 set.
                for (int w = 0; w < L2_WAYS; w++)
                begin
                    if (row[w].valid)
                    begin
                        wn = wn + WN_W'(1);
                        if (!l2_hit && row[w].blk == cur_reg.blk)
                        begin
                            l2_hit = 1'b1;
                            wh     = w;
                        end
                    end
                end
                l2_hit = l2_hit && !l1_hit && !v_hit;

                // Victim hit: close the gap in the age order.
                if (v_hit)
                begin
                    vpos = v_lru_reg[vh];
                    for (int i = 0; i < VICTIM_ENTRIES; i++)
                    begin
                        if (v_valid_reg[i] && v_lru_reg[i] > vpos)
                        begin
                            v_lru_next[i] = v_lru_reg[i] - VI_W'(1);
                        end
                    end
                    if (cur_reg.is_read)
                    begin
                        rdata           = v_data_reg[vh];
                        v_valid_next[vh] = 1'b0;
                    end
                    else
                    begin
                        v_data_next[vh] = cur_reg.wdata;
                        v_lru_next[vh]  = VI_W'(vn - VN_W'(1));
                    end
                end

                // L2 hit: same treatment inside the set, then write back.
                if (l2_hit)
                begin
                    wpos = row[wh].lru;
                    for (int w = 0; w < L2_WAYS; w++)
                    begin
                        if (row[w].valid && row[w].lru > wpos)
                        begin
                            row[w].lru = row[w].lru - WL_W'(1);
                        end
                    end
                    if (cur_reg.is_read)
                    begin
                        rdata          = row[wh].data;
                        row[wh].valid  = 1'b0;
                    end
                    else
                    begin
                        row[wh].data = cur_reg.wdata;
                        row[wh].lru  = WL_W'(wn - WN_W'(1));
                    end
                    l2_we = 1'b1;
                    l2_wd = row;
                    l2_ok_next[l2_rset_reg] = 1'b1;
                end

                if (l1_hit)
                begin
                    rdata = l1_rd_reg.data;
                    if (!cur_reg.is_read)
                    begin
                        l1_we = 1'b1;
                        l1_wd = '{blk: cur_reg.blk, data: cur_reg.wdata};
                    end
                end
                else if (cur_reg.is_read)
                begin
                    // Fill L1; a valid line there moves into the victim buffer.
                    l1_we = 1'b1;
                    l1_wd = '{blk: cur_reg.blk, data: rdata};
                    l1_valid_next[idx] = 1'b1;
                    if (l1_valid_reg[idx])
                    begin
                        vn = '0;
                        for (int i = VICTIM_ENTRIES - 1; i >= 0; i--)
                        begin
                            if (v_valid_next[i])
                            begin
                                if (v_lru_next[i] == '0)
                                begin
                                    oi = i;
                                end
                            end
                            else
                            begin
                                free_found = 1'b1;
                                fi         = i;
                            end
                        end
                        for (int i = 0; i < VICTIM_ENTRIES; i++)
                        begin
                            if (v_valid_next[i])
                            begin
                                vn = vn + VN_W'(1);
                            end
                        end
                        if (free_found)
                        begin
                            v_valid_next[fi] = 1'b1;
                            v_blk_next[fi]   = l1_rd_reg.blk;
                            v_data_next[fi]  = l1_rd_reg.data;
                            v_lru_next[fi]   = VI_W'(vn);
                        end
                        else
                        begin
                            cascade      = 1'b1;
                            ev_blk_next  = v_blk_next[oi];
                            ev_data_next = v_data_next[oi];
                            for (int i = 0; i < VICTIM_ENTRIES; i++)
                            begin
                                if (v_lru_next[i] != '0)
                                begin
                                    v_lru_next[i] = v_lru_next[i] - VI_W'(1);
                                end
                            end
                            v_valid_next[oi] = 1'b1;
                            v_blk_next[oi]   = l1_rd_reg.blk;
                            v_data_next[oi]  = l1_rd_reg.data;
                            v_lru_next[oi]   = VI_W'(VICTIM_ENTRIES - 1);
                        end
                    end
                end

                // Miss counts and result.
                if (!l1_hit)
                begin
                    l1m_next = l1m_reg + CNT_W'(1);
                    if (!v_hit)
                    begin
                        vm_next = vm_reg + CNT_W'(1);
                        if (!l2_hit)
                        begin
                            l2m_next = l2m_reg + CNT_W'(1);
                        end
                    end
                end
                res_data_next = cur_reg.is_read ? rdata : '0;
                if (l1_hit)
                begin
                    res_lvl_next = LVL_L1;
                end
                else if (v_hit)
                begin
                    res_lvl_next = LVL_VB;
                end
                else if (l2_hit)
                begin
                    res_lvl_next = LVL_L2;
                end
                else
                begin
                    res_lvl_next = LVL_MEM;
                end
            end
            ST_L2WR:
            begin
                // Insert the buffer's oldest entry into its L2 set.
                for (int w = L2_WAYS - 1; w >= 0; w--)
                begin
                    if (row[w].valid)
                    begin
                        if (row[w].lru == '0)
                        begin
                            oi = w;
                        end
                    end
                    else
                    begin
                        free_found = 1'b1;
                        fi         = w;
                    end
                end
                for (int w = 0; w < L2_WAYS; w++)
                begin
                    if (row[w].valid)
                    begin
                        wn = wn + WN_W'(1);
                    end
                end
                if (free_found)
                begin
                    row[fi] = '{valid: 1'b1, blk: ev_blk_reg, lru: WL_W'(wn),
                                data: ev_data_reg};
                end
                else
                begin
                    for (int w = 0; w < L2_WAYS; w++)
                    begin
                        if (row[w].lru != '0)
                        begin
                            row[w].lru = row[w].lru - WL_W'(1);
                        end
                    end
                    row[oi] = '{valid: 1'b1, blk: ev_blk_reg, lru: WL_W'(L2_WAYS - 1),
                                data: ev_data_reg};
                end
                l2_we = 1'b1;
                l2_wd = row;
                l2_ok_next[l2_rset_reg] = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_lvl_next   = res_lvl_reg;
                    out_l1m_next   = l1m_reg;
                    out_vm_next    = vm_reg;
                    out_l2m_next   = l2m_reg;
                end
            end
            default:
            begin
                cascade = 1'b0;
            end
        endcase
    end

    // Control and cache state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            l1_valid_reg  <= '0;
            l2_ok_reg     <= '0;
            l1m_reg       <= '0;
            vm_reg        <= '0;
            l2m_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VICTIM_ENTRIES; i++)
            begin
                v_valid_reg[i] <= 1'b0;
                v_blk_reg[i]   <= '0;
                v_lru_reg[i]   <= '0;
                v_data_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            l1_valid_reg  <= l1_valid_next;
            l2_ok_reg     <= l2_ok_next;
            l1m_reg       <= l1m_next;
            vm_reg        <= vm_next;
            l2m_reg       <= l2m_next;
            out_valid_reg <= out_valid_next;
            v_valid_reg   <= v_valid_next;
            v_blk_reg     <= v_blk_next;
            v_lru_reg     <= v_lru_next;
            v_data_reg    <= v_data_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        ev_blk_reg   <= ev_blk_next;
        ev_data_reg  <= ev_data_next;
        res_data_reg <= res_data_next;
        res_lvl_reg  <= res_lvl_next;
        out_data_reg <= out_data_next;
        out_lvl_reg  <= out_lvl_next;
        out_l1m_reg  <= out_l1m_next;
        out_vm_reg   <= out_vm_next;
        out_l2m_reg  <= out_l2m_next;
    end

    // L1 line memory.
    always_ff @(posedge clk)
    begin
        if (l1_we)
        begin
            l1_mem[l1_wa] <= l1_wd;
        end
        l1_rd_reg <= l1_mem[l1_ra];
    end

    // L2 row memory.
    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_wa] <= l2_wd;
        end
        l2_rd_reg   <= l2_mem[l2_ra];
        l2_rset_reg <= l2_ra;
    end

    // Main memory.
    always_ff @(posedge clk)
    begin
        if (mm_we)
        begin
            mm_mem[mm_wa] <= mm_wd;
        end
        mm_rd_reg <= mm_mem[mm_ra];
    end

endmodule

[sv/exclusive_cache_hierarchy_victim.sv]
// A request is registered in the request queue, then passes the idle, lookup and result
// steps of the back end and on to the output register; the L2 re-read and write steps
// come between lookup and result when the victim buffer's oldest entry must go into its
// L2 set. The back end takes one request at a time, so a new one waits in the queue.
// Reset: caches invalid and counters zero at once; main memory is then cleared
// word by word, during which no request is taken.
module exclusive_cache_hierarchy_victim #(
    parameter int L1_SETS        = 16,
    parameter int VICTIM_ENTRIES = 4,
    parameter int L2_SETS        = 16,
    parameter int L2_WAYS        = 8,
    parameter int MEM_BYTES      = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          is_read,
    input  logic [ech_pkg::ADDR_W-1:0]    address,
    input  logic [ech_pkg::WORD_W-1:0]    write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ech_pkg::WORD_W-1:0]    read_data,
    output logic [ech_pkg::LVL_W-1:0]     hit_level,
    output logic [ech_pkg::CNT_W-1:0]     l1_miss_count,
    output logic [ech_pkg::CNT_W-1:0]     victim_miss_count,
    output logic [ech_pkg::CNT_W-1:0]     l2_miss_count
);
    import ech_pkg::*;

    logic     head_valid;
    ech_req_t head;
    logic     pop;
    logic     clearing;

    // Request queue.
    ech_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .is_read    (is_read),
        .address    (address),
        .write_data (write_data),
        .hold       (clearing),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Cache hierarchy engine.
    ech_back #(
        .L1_SETS        (L1_SETS),
        .VICTIM_ENTRIES (VICTIM_ENTRIES),
        .L2_SETS        (L2_SETS),
        .L2_WAYS        (L2_WAYS),
        .MEM_BYTES      (MEM_BYTES)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop),
        .clearing          (clearing),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .hit_level         (hit_level),
        .l1_miss_count     (l1_miss_count),
        .victim_miss_count (victim_miss_count),
        .l2_miss_count     (l2_miss_count)
    );

endmodule

[sv/ech_checker.sv]
// Port-level checks of the cache hierarchy, bound to the top level.
`include "exclusive_cache_hierarchy_victim_assert.svh"

module ech_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_data,
    input logic [31:0] l1_miss_count,
    input logic [31:0] victim_miss_count,
    input logic [31:0] l2_miss_count
);

    // A stalled result stays put.
    `ECHV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data), "result changed while stalled")

    // A victim miss is always preceded by an L1 miss on the same request.
    `ECHV_ASSERT_NOW(a_vm_le_l1m, out_valid, victim_miss_count <= l1_miss_count, "victim misses exceed L1 misses")

    // An L2 miss is always preceded by a victim miss.
    `ECHV_ASSERT_NOW(a_l2m_le_vm, out_valid, l2_miss_count <= victim_miss_count, "L2 misses exceed victim misses")

endmodule

bind exclusive_cache_hierarchy_victim ech_checker u_ech_checker (.*);
